@@ rtl/tcc_pkg.sv @@
// Shared types, field layout and constants of the text console cell engine.
`default_nettype none

package tcc_pkg;

    // default geometry
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_TAB_STOP = 8;

    // field widths
    localparam int CMD_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int POSX_W  = 7;
    localparam int POSY_W  = 6;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = CHAR_W + COLOR_W;

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ACOLS_W    = 8;
    localparam int AROWS_W    = 7;
    localparam int RSVD_W     = 6;

    localparam logic [COLOR_W-1:0] RESET_TEXT_COLOR = 8'h0F;
    localparam logic [ACOLS_W-1:0] RESET_ACOLS      = 8'd80;
    localparam logic [AROWS_W-1:0] RESET_AROWS      = 7'd25;
    localparam logic [RSVD_W-1:0]  RESET_RSVD       = 6'd0;

    // request layout: cmd, char_code, pos_x, pos_y, cell_color from bit 0 up
    localparam int OFS_CHAR   = CMD_W;
    localparam int OFS_POSX   = OFS_CHAR + CHAR_W;
    localparam int OFS_POSY   = OFS_POSX + POSX_W;
    localparam int OFS_COLOR  = OFS_POSY + POSY_W;
    localparam int IN_BITS    = OFS_COLOR + COLOR_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

    // result layout: cursor_col, cursor_row, scrolled, read_char, read_color
    localparam int OFS_OROW   = POSX_W;
    localparam int OFS_SCROLL = OFS_OROW + POSY_W;
    localparam int OFS_RCHAR  = OFS_SCROLL + 1;
    localparam int OFS_RCOLOR = OFS_RCHAR + CHAR_W;
    localparam int OUT_BITS   = OFS_RCOLOR + COLOR_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_TEXT_COLOR, CH_SPACE};

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT        = 3'd0,
        CMD_WRITE      = 3'd1,
        CMD_SET_CURSOR = 3'd2,
        CMD_READ       = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXT_COLOR    = 2'd0,
        CFG_ACTIVE_COLS   = 2'd1,
        CFG_ACTIVE_ROWS   = 2'd2,
        CFG_RESERVED_ROWS = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_SWEEP,
        ST_IDLE,
        ST_READ
    } t_state;

endpackage

`default_nettype wire

@@ rtl/text_console_cell_engine.sv @@
// Top level of the text console cell engine: command decode, cursor, config, result register.
//
// Text cells of 16 bits (character low byte, attribute high byte) live in a
// MAX_COLS x MAX_ROWS single-port-write memory at row * MAX_COLS + col. Put
// character, write at position, set cursor and unused commands have their
// result registered at the accepting edge. Read cell loads its result from
// the registered memory read once the output register is free. A put that
// scrolls, and clear, hold off the next request while the store is swept
// one cell per cycle through the single write port. After reset the store
// is cleared to 0x0F20 the same way; no request is accepted until that
// sweep is done, while configuration writes are taken throughout. Results
// are held in an output register, so a request can be taken while the
// previous result is drained.
`default_nettype none

module text_console_cell_engine import tcc_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int TAB_STOP = DEF_TAB_STOP
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // cmd, char_code, pos_x, pos_y, cell_color from bit 0 up
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cursor_col, cursor_row, scrolled, read_char, read_color from bit 0 up
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_COLS + TAB_STOP);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int XCW0  = (XW > POSX_W) ? XW : POSX_W;
    localparam int XCW   = (XCW0 > ACOLS_W) ? XCW0 : ACOLS_W + 1;
    localparam int YCW0  = (RW > POSY_W) ? RW : POSY_W;
    localparam int YCW   = (YCW0 > AROWS_W) ? YCW0 : AROWS_W + 1;

    // configuration
    logic [COLOR_W-1:0] r_text_color;
    logic [ACOLS_W-1:0] r_active_cols;
    logic [AROWS_W-1:0] r_active_rows;
    logic [RSVD_W-1:0]  r_reserved_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color    <= RESET_TEXT_COLOR;
            r_active_cols   <= RESET_ACOLS;
            r_active_rows   <= RESET_AROWS;
            r_reserved_rows <= RESET_RSVD;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TEXT_COLOR:    r_text_color    <= i_cfg_wdata[COLOR_W-1:0];
                CFG_ACTIVE_COLS:   r_active_cols   <= i_cfg_wdata[ACOLS_W-1:0];
                CFG_ACTIVE_ROWS:   r_active_rows   <= i_cfg_wdata[AROWS_W-1:0];
                CFG_RESERVED_ROWS: r_reserved_rows <= i_cfg_wdata[RSVD_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [XCW-1:0] cols;
    logic [YCW-1:0] rows;
    logic [YCW-1:0] rsvd;
    logic [YCW-1:0] height;

    always_comb begin
        cols = XCW'(r_active_cols);
        if (cols == '0) begin
            cols = XCW'(1);
        end else if (cols > XCW'(MAX_COLS)) begin
            cols = XCW'(MAX_COLS);
        end
        rows = YCW'(r_active_rows);
        if (rows == '0) begin
            rows = YCW'(1);
        end else if (rows > YCW'(MAX_ROWS)) begin
            rows = YCW'(MAX_ROWS);
        end
        rsvd = YCW'(r_reserved_rows);
        if (rsvd > rows - YCW'(1)) begin
            rsvd = rows - YCW'(1);
        end
        height = rows - rsvd;
    end

    // request fields
    t_cmd               in_cmd;
    logic [CHAR_W-1:0]  in_char;
    logic [POSX_W-1:0]  in_posx;
    logic [POSY_W-1:0]  in_posy;
    logic [COLOR_W-1:0] in_color;

    assign in_cmd   = t_cmd'(s_tdata[CMD_W-1:0]);
    assign in_char  = s_tdata[OFS_CHAR  +: CHAR_W];
    assign in_posx  = s_tdata[OFS_POSX  +: POSX_W];
    assign in_posy  = s_tdata[OFS_POSY  +: POSY_W];
    assign in_color = s_tdata[OFS_COLOR +: COLOR_W];

    // next tab stop for each column
    logic [XW-1:0] tab_next [MAX_COLS];

    for (genvar gi = 0; gi < MAX_COLS; gi++) begin : g_tab
        assign tab_next[gi] = XW'(gi + TAB_STOP - (gi % TAB_STOP));
    end

    // cursor
    logic [COL_W-1:0] r_cx, n_cx;
    logic [ROW_W-1:0] r_cy, n_cy;

    // put character
    logic [XCW-1:0]    cur_x;
    logic [YCW-1:0]    cur_y;
    logic [XCW-1:0]    put_x;
    logic [YCW-1:0]    put_yraw;
    logic [YCW-1:0]    put_y;
    logic [XCW-1:0]    st_x;
    logic [CHAR_W-1:0] st_char;
    logic              st_en;
    logic              put_hit;
    logic              put_scroll;

    always_comb begin
        cur_x    = XCW'(r_cx);
        cur_y    = YCW'(r_cy);
        put_x    = cur_x;
        put_yraw = cur_y;
        st_x     = cur_x;
        st_char  = in_char;
        st_en    = 1'b0;
        case (in_char)
            CH_LF: begin
                put_x    = '0;
                put_yraw = cur_y + YCW'(1);
            end
            CH_CR: begin
                put_x = '0;
            end
            CH_TAB: begin
                put_x = XCW'(tab_next[r_cx]);
            end
            CH_BS: begin
                // backspace blanks the cell it steps back onto
                if (cur_x != '0) begin
                    put_x   = cur_x - XCW'(1);
                    st_x    = cur_x - XCW'(1);
                    st_char = CH_SPACE;
                    st_en   = 1'b1;
                end
            end
            default: begin
                put_x = cur_x + XCW'(1);
                st_en = 1'b1;
            end
        endcase
        if (put_x >= cols) begin
            put_x    = '0;
            put_yraw = put_yraw + YCW'(1);
        end
        put_scroll = put_yraw >= height;
        put_y      = put_scroll ? height - YCW'(1) : put_yraw;
        put_hit    = st_en && (st_x < cols) && (cur_y < rows);
    end

    // positioned commands
    logic           pos_hit;
    logic [XCW-1:0] sat_x;
    logic [YCW-1:0] sat_y;

    always_comb begin
        pos_hit = (XCW'(in_posx) < cols) && (YCW'(in_posy) < rows);
        sat_x   = (XCW'(in_posx) > cols - XCW'(1)) ? cols - XCW'(1) : XCW'(in_posx);
        sat_y   = (YCW'(in_posy) > rows - YCW'(1)) ? rows - YCW'(1) : YCW'(in_posy);
    end

    // control
    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free = !r_out_valid || m_tready;
    assign s_tready = (r_state == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    logic              sw_busy;
    logic              sw_start;
    logic [ROW_W-1:0]  sw_copy_rows;
    logic [ROW_W-1:0]  sw_last_row;
    logic [CELL_W-1:0] sw_blank;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (!sw_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_READ) begin
                        n_state = ST_READ;
                    end else if ((in_cmd == CMD_CLEAR) ||
                                 ((in_cmd == CMD_PUT) && put_scroll)) begin
                        n_state = ST_SWEEP;
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    logic              top_we;
    logic              top_re;
    logic [CELL_W-1:0] top_wdata;
    logic [COL_W-1:0]  sel_x;
    logic [ROW_W-1:0]  sel_y;
    logic [AW-1:0]     top_addr;
    logic              out_load;
    logic              out_scrolled;
    logic [CELL_W-1:0] out_rdata;
    logic [CELL_W-1:0] mem_rdata;
    logic              r_rd_hit;

    always_comb begin
        sw_start     = 1'b0;
        sw_copy_rows = '0;
        sw_last_row  = ROW_W'(MAX_ROWS - 1);
        sw_blank     = RESET_BLANK;
        top_we       = 1'b0;
        top_re       = 1'b0;
        top_wdata    = {r_text_color, st_char};
        sel_x        = COL_W'(st_x);
        sel_y        = r_cy;
        out_load     = 1'b0;
        out_scrolled = 1'b0;
        out_rdata    = '0;
        n_cx         = r_cx;
        n_cy         = r_cy;
        case (r_state)
            ST_INIT: sw_start = 1'b1;
            ST_IDLE: begin
                if (accept) begin
                    out_load = 1'b1;
                    case (in_cmd)
                        CMD_PUT: begin
                            top_we       = put_hit;
                            n_cx         = COL_W'(put_x);
                            n_cy         = ROW_W'(put_y);
                            out_scrolled = put_scroll;
                            if (put_scroll) begin
                                sw_start     = 1'b1;
                                sw_copy_rows = ROW_W'(height - YCW'(1));
                                sw_last_row  = ROW_W'(height - YCW'(1));
                                sw_blank     = {r_text_color, CH_SPACE};
                            end
                        end
                        CMD_WRITE: begin
                            top_we    = pos_hit;
                            top_wdata = {in_color, in_char};
                            sel_x     = COL_W'(in_posx);
                            sel_y     = ROW_W'(in_posy);
                        end
                        CMD_SET_CURSOR: begin
                            n_cx = COL_W'(sat_x);
                            n_cy = ROW_W'(sat_y);
                        end
                        CMD_READ: begin
                            top_re   = 1'b1;
                            out_load = 1'b0;
                            sel_x    = COL_W'(in_posx);
                            sel_y    = ROW_W'(in_posy);
                        end
                        CMD_CLEAR: begin
                            sw_start = 1'b1;
                            sw_blank = {r_text_color, CH_SPACE};
                            n_cx     = '0;
                            n_cy     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_rd_hit) begin
                        out_rdata = mem_rdata;
                    end
                end
            end
            default: ;
        endcase
    end

    // address of a selected cell, used only when it lies in the area
    assign top_addr = AW'(AW'(sel_y) * AW'(MAX_COLS)) + AW'(sel_x);

    logic [OUT_DATA_W-1:0] r_out, n_out;

    always_comb begin
        n_out                           = '0;
        n_out[0 +: POSX_W]              = POSX_W'(n_cx);
        n_out[OFS_OROW +: POSY_W]       = POSY_W'(n_cy);
        n_out[OFS_SCROLL]               = out_scrolled;
        n_out[OFS_RCHAR +: CHAR_W]      = out_rdata[CHAR_W-1:0];
        n_out[OFS_RCOLOR +: COLOR_W]    = out_rdata[CELL_W-1:CHAR_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cx        <= '0;
            r_cy        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
        if (top_re) begin
            r_rd_hit <= pos_hit;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out;

    // memory and sweep
    logic              sw_re;
    logic [AW-1:0]     sw_raddr;
    logic              sw_we;
    logic [AW-1:0]     sw_waddr;
    logic [CELL_W-1:0] sw_wdata;

    tcc_sweep #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (sw_start),
        .i_copy_rows (sw_copy_rows),
        .i_last_row  (sw_last_row),
        .i_blank     (sw_blank),
        .i_rdata     (mem_rdata),
        .o_busy      (sw_busy),
        .o_re        (sw_re),
        .o_raddr     (sw_raddr),
        .o_we        (sw_we),
        .o_waddr     (sw_waddr),
        .o_wdata     (sw_wdata)
    );

    tcc_cell_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (sw_busy ? sw_we    : top_we),
        .i_waddr (sw_busy ? sw_waddr : top_addr),
        .i_wdata (sw_busy ? sw_wdata : top_wdata),
        .i_re    (sw_busy ? sw_re    : top_re),
        .i_raddr (sw_busy ? sw_raddr : top_addr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

@@ rtl/tcc_cell_mem.sv @@
// Cell store: one write port, one registered read port.
`default_nettype none

module tcc_cell_mem import tcc_pkg::*; #(
    parameter int DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CELL_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/tcc_sweep.sv @@
// Store sweep: row copy for scrolling, then blank fill, one cell per cycle.
`default_nettype none

module tcc_sweep import tcc_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int COL_W = $clog2(MAX_COLS),
    localparam int ROW_W = $clog2(MAX_ROWS),
    localparam int AW    = $clog2(MAX_COLS * MAX_ROWS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ROW_W-1:0]  i_copy_rows,
    input  logic [ROW_W-1:0]  i_last_row,
    input  logic [CELL_W-1:0] i_blank,
    input  logic [CELL_W-1:0] i_rdata,
    output logic              o_busy,
    output logic              o_re,
    output logic [AW-1:0]     o_raddr,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [CELL_W-1:0] o_wdata
);

    logic              r_busy, n_busy;
    logic [AW-1:0]     r_addr, n_addr;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ROW_W-1:0]  r_copy_rows;
    logic [ROW_W-1:0]  r_last_row;
    logic [CELL_W-1:0] r_blank;
    logic              r_wr_vld;
    logic              r_wr_copy;
    logic [AW-1:0]     r_wr_addr;
    logic              copying;
    logic              at_end;

    assign copying = r_row < r_copy_rows;
    assign at_end  = (r_row == r_last_row) && (r_col == COL_W'(MAX_COLS - 1));

    always_comb begin
        n_busy = r_busy;
        n_addr = r_addr;
        n_col  = r_col;
        n_row  = r_row;
        if (i_start) begin
            n_busy = 1'b1;
            n_addr = '0;
            n_col  = '0;
            n_row  = '0;
        end else if (r_busy) begin
            n_addr = r_addr + AW'(1);
            if (r_col == COL_W'(MAX_COLS - 1)) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
            if (at_end) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_wr_vld <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_wr_vld <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_col     <= n_col;
        r_row     <= n_row;
        r_wr_copy <= copying;
        r_wr_addr <= r_addr;
        if (i_start) begin
            r_copy_rows <= i_copy_rows;
            r_last_row  <= i_last_row;
            r_blank     <= i_blank;
        end
    end

    // copy reads the cell one row below; its write lands in the following cycle
    assign o_re    = r_busy && copying;
    assign o_raddr = r_addr + AW'(MAX_COLS);
    assign o_we    = r_wr_vld;
    assign o_waddr = r_wr_addr;
    assign o_wdata = r_wr_copy ? i_rdata : r_blank;
    assign o_busy  = r_busy | r_wr_vld;

endmodule

`default_nettype wire

@@ rtl/tcc_checker.sv @@
// Port-level checks of the text console cell engine, bound to the top level.
`default_nettype none

module tcc_checker import tcc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // reset empties the result register and starts the clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && !s_tready)
        else $error("result or ready active right after reset");

    // a request either yields a result next cycle or holds off the next request
    a_req_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> m_tvalid || !s_tready)
        else $error("request accepted without result or hold-off");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // read data and scroll flag never come from the same request
    a_read_vs_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && ((m_tdata[OFS_RCHAR +: CHAR_W] != '0) ||
                     (m_tdata[OFS_RCOLOR +: COLOR_W] != '0)) |-> !m_tdata[OFS_SCROLL])
        else $error("read result flagged as scrolled");

endmodule

bind text_console_cell_engine tcc_checker u_tcc_checker (.*);

`default_nettype wire
